[hdl/u8d_pkg.sv]
package u8d_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        is_error;
        logic        truncated;
        logic [2:0]  byte_count;
        logic        last_of_run;
    } out_t;

    // Work for one input transaction: plain errors, then an optional lead
    // result, then truncated errors.
    typedef struct packed {
        logic [2:0]  n_err;
        logic        lead_valid;
        logic [20:0] lead_cp;
        logic        lead_err;
        logic [2:0]  lead_cnt;
        logic [1:0]  n_trunc;
    } desc_t;

endpackage

[hdl/u8d_front.sv]
module u8d_front
    import u8d_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  in_t   s_data,
    output logic  push,
    output desc_t push_desc,
    input  logic  q_ready
);

    logic [1:0]  held_reg, held_next;
    logic [2:0]  seqlen_reg, seqlen_next;
    logic [20:0] partial_reg, partial_next;
    logic        accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    always_comb begin
        logic [7:0]  b;
        logic        do_lead;
        logic        ok;
        logic [2:0]  h;
        logic [20:0] pv;
        logic [2:0]  total;

        b            = s_data.data_byte;
        do_lead      = 1'b0;
        ok           = 1'b0;
        h            = {1'b0, held_reg} + 3'd1;
        pv           = {partial_reg[14:0], b[5:0]};
        held_next    = held_reg;
        seqlen_next  = seqlen_reg;
        partial_next = partial_reg;
        push_desc    = '0;
        push_desc.lead_cp = REPLACEMENT;

        if (s_data.has_byte) begin
            if (held_reg != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    if (h >= seqlen_reg) begin
                        case (seqlen_reg)
                            3'd2: ok = (pv > 21'h7F);
                            3'd3: ok = (pv > 21'h7FF) && !(pv >= SURR_LO && pv <= SURR_HI);
                            default: ok = (pv > 21'hFFFF) && (pv <= MAX_SCALAR);
                        endcase
                        if (ok) begin
                            push_desc.lead_valid = 1'b1;
                            push_desc.lead_cp    = pv;
                            push_desc.lead_cnt   = seqlen_reg;
                        end else begin
                            push_desc.n_err = h;
                        end
                        held_next    = 2'd0;
                        seqlen_next  = 3'd0;
                        partial_next = '0;
                    end else begin
                        held_next    = h[1:0];
                        partial_next = pv;
                    end
                end else begin
                    // missing continuation: flush held bytes, re-decode this one
                    push_desc.n_err = {1'b0, held_reg};
                    held_next    = 2'd0;
                    seqlen_next  = 3'd0;
                    partial_next = '0;
                    do_lead      = 1'b1;
                end
            end else begin
                do_lead = 1'b1;
            end
        end

        if (do_lead) begin
            case (b) inside
                [8'h00:8'h7F]: begin
                    push_desc.lead_valid = 1'b1;
                    push_desc.lead_cp    = {13'd0, b};
                    push_desc.lead_cnt   = 3'd1;
                end
                [8'hC0:8'hDF]: begin
                    held_next    = 2'd1;
                    seqlen_next  = 3'd2;
                    partial_next = {16'd0, b[4:0]};
                end
                [8'hE0:8'hEF]: begin
                    held_next    = 2'd1;
                    seqlen_next  = 3'd3;
                    partial_next = {17'd0, b[3:0]};
                end
                [8'hF0:8'hF7]: begin
                    held_next    = 2'd1;
                    seqlen_next  = 3'd4;
                    partial_next = {18'd0, b[2:0]};
                end
                default: begin
                    push_desc.lead_valid = 1'b1;
                    push_desc.lead_err   = 1'b1;
                    push_desc.lead_cnt   = 3'd1;
                end
            endcase
        end

        if (s_data.end_of_stream) begin
            push_desc.n_trunc = held_next;
            held_next    = 2'd0;
            seqlen_next  = 3'd0;
            partial_next = '0;
        end

        total = push_desc.n_err + {2'd0, push_desc.lead_valid} + {1'b0, push_desc.n_trunc};
        push  = accept && (total != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 2'd0;
            seqlen_reg  <= 3'd0;
            partial_reg <= '0;
        end else if (accept) begin
            held_reg    <= held_next;
            seqlen_reg  <= seqlen_next;
            partial_reg <= partial_next;
        end
    end

endmodule

[hdl/u8d_queue.sv]
module u8d_queue
    import u8d_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  q_ready,
    output logic  q_valid,
    output desc_t q_desc,
    input  logic  pop
);

    desc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign q_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_desc  = mem_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hdl/u8d_back.sv]
module u8d_back
    import u8d_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    input  desc_t q_desc,
    output logic  pop,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    logic [1:0] k_reg, k_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;
    logic       load;
    logic       last;
    logic [2:0] k3;
    logic [2:0] total;
    out_t       res;

    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign k3      = {1'b0, k_reg};
    assign total   = q_desc.n_err + {2'd0, q_desc.lead_valid} + {1'b0, q_desc.n_trunc};
    assign last    = (k3 + 3'd1 == total);
    assign pop     = load && last;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        res            = '0;
        res.code_point = REPLACEMENT;
        res.is_error   = 1'b1;
        res.byte_count = 3'd1;
        res.last_of_run = last;
        if (k3 < q_desc.n_err) begin
            res.truncated = 1'b0;
        end else if (q_desc.lead_valid && k3 == q_desc.n_err) begin
            res.code_point = q_desc.lead_cp;
            res.is_error   = q_desc.lead_err;
            res.byte_count = q_desc.lead_cnt;
        end else begin
            res.truncated = 1'b1;
        end
    end

    always_comb begin
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
            k_next       = last ? 2'd0 : k_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/utf8_stream_decoder.sv]
// Channel   Ports                        Payload
// input     s_valid, s_ready, s_data     in_t  : data_byte, has_byte, end_of_stream
// result    m_valid, m_ready, m_data     out_t : code_point, is_error, truncated,
//                                                byte_count, last_of_run
//
// One input byte is taken per cycle while the 4-entry descriptor queue has room.
// Each result goes through the output register, which stalls on m_ready; a transaction that
// yields n results holds its queue entry until the n-th result is loaded.
// aresetn is synchronous, active low: clears the held sequence, queue and output valid.
// The input stalls only when the queue is full; the output register stalls on m_ready.
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic  push, q_ready, q_valid, pop;
    desc_t push_desc, q_desc;

    u8d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready)
    );

    u8d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_desc    (q_desc),
        .pop       (pop)
    );

    u8d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_desc  (q_desc),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[hdl/u8d_checker.sv]
module u8d_checker
    import u8d_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_error |->
            m_data.code_point == REPLACEMENT && m_data.byte_count == 3'd1)
        else $error("error result malformed");

    a_good_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_error |->
            !m_data.truncated && m_data.byte_count != 3'd0 && m_data.byte_count <= 3'd4
            && !(m_data.code_point >= SURR_LO && m_data.code_point <= SURR_HI)
            && m_data.code_point <= MAX_SCALAR)
        else $error("good result malformed");

    a_ascii_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_error && m_data.byte_count == 3'd1 |->
            m_data.code_point <= 21'h7F)
        else $error("single byte result above ASCII");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind utf8_stream_decoder u8d_checker u_chk (.*);

[bench/utf8_stream_decoder_tb.sv]
`timescale 1ns / 100ps

module utf8_stream_decoder_tb
    import u8d_pkg::*;
();

    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int UNITS_ITEMS  = 95;

    typedef enum int {
        UNIT_VALID,
        UNIT_RAW,
        UNIT_CUT,
        UNIT_NOISE,
        UNIT_FLUSH
    } unit_kind_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    in_t  byte_stream[$];
    out_t expected_cps[$];

    // decoder state mirror
    logic [1:0]  held_bytes    = 2'd0;
    logic [2:0]  announced_len = 3'd0;
    logic [20:0] partial_cp    = 21'd0;

    int send_idle_pct = 11;
    int recv_idle_pct = 61;
    int fail_count    = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    utf8_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic out_t replacement(input logic trunc);
        return out_t'{code_point: REPLACEMENT, is_error: 1'b1, truncated: trunc,
                      byte_count: 3'd1, last_of_run: 1'b0};
    endfunction

    function automatic logic legal_scalar(input logic [2:0] len, input logic [20:0] v);
        case (len)
            3'd2: return v > 21'h7F;
            3'd3: return v > 21'h7FF && !(v >= SURR_LO && v <= SURR_HI);
            default: return v > 21'hFFFF && v <= MAX_SCALAR;
        endcase
    endfunction

    task automatic drop_sequence();
        held_bytes    = 2'd0;
        announced_len = 3'd0;
        partial_cp    = 21'd0;
    endtask

    task automatic decode_transaction(input in_t t);
        out_t        runs[$];
        out_t        tail;
        logic        consumed;
        logic [2:0]  next_held;
        logic [20:0] grown;
        logic [7:0]  b;
        consumed = 1'b0;
        b = t.data_byte;
        if (t.has_byte) begin
            if (held_bytes != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    next_held = {1'b0, held_bytes} + 3'd1;
                    grown = {partial_cp[14:0], b[5:0]};
                    consumed = 1'b1;
                    if (next_held >= announced_len) begin
                        if (legal_scalar(announced_len, grown))
                            runs.push_back(out_t'{code_point: grown, is_error: 1'b0,
                                                  truncated: 1'b0, byte_count: announced_len,
                                                  last_of_run: 1'b0});
                        else
                            repeat (next_held) runs.push_back(replacement(1'b0));
                        drop_sequence();
                    end else begin
                        held_bytes = next_held[1:0];
                        partial_cp = grown;
                    end
                end else begin
                    // broken sequence: report held bytes, then redecode b as a lead
                    repeat (held_bytes) runs.push_back(replacement(1'b0));
                    drop_sequence();
                end
            end
            if (!consumed) begin
                if (b < 8'h80) begin
                    runs.push_back(out_t'{code_point: {13'd0, b}, is_error: 1'b0,
                                          truncated: 1'b0, byte_count: 3'd1,
                                          last_of_run: 1'b0});
                end else if (b < 8'hC0) begin
                    runs.push_back(replacement(1'b0));
                end else if (b < 8'hE0) begin
                    held_bytes = 2'd1; announced_len = 3'd2; partial_cp = {16'd0, b[4:0]};
                end else if (b < 8'hF0) begin
                    held_bytes = 2'd1; announced_len = 3'd3; partial_cp = {17'd0, b[3:0]};
                end else if (b < 8'hF8) begin
                    held_bytes = 2'd1; announced_len = 3'd4; partial_cp = {18'd0, b[2:0]};
                end else begin
                    runs.push_back(replacement(1'b0));
                end
            end
        end
        if (t.end_of_stream) begin
            repeat (held_bytes) runs.push_back(replacement(1'b1));
            drop_sequence();
        end
        if (runs.size() != 0) begin
            tail = runs.pop_back();
            tail.last_of_run = 1'b1;
            runs.push_back(tail);
        end
        foreach (runs[i]) expected_cps.push_back(runs[i]);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eos = 1'b0);
        byte_stream.push_back(in_t'{data_byte: b, has_byte: 1'b1, end_of_stream: eos});
    endtask

    task automatic push_flush(input logic eos);
        byte_stream.push_back(in_t'{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                                    end_of_stream: eos});
    endtask

    // Queue one random sequence; return how many items the block acts on.
    task automatic queue_random_unit(output int counted);
        unit_kind_t  kind;
        logic [7:0]  seq[4];
        logic [20:0] cp, lo, hi;
        logic        eos;
        int          pick, len, keep;
        pick = $urandom_range(0, 99);
        if (pick < 55)      kind = UNIT_VALID;
        else if (pick < 72) kind = UNIT_RAW;
        else if (pick < 84) kind = UNIT_CUT;
        else if (pick < 94) kind = UNIT_NOISE;
        else                kind = UNIT_FLUSH;
        len = $urandom_range(1, 4);
        eos = ($urandom_range(0, 19) == 0);
        counted = 0;
        case (kind)
            UNIT_FLUSH: begin
                eos = 1'($urandom_range(0, 1));
                push_flush(eos);
                counted = eos ? 1 : 0;
            end
            UNIT_NOISE: begin
                push_byte(8'($urandom_range(0, 255)), eos);
                counted = 1;
            end
            default: begin
                if (kind == UNIT_CUT && len == 1) len = 2;
                case (len)
                    1: begin lo = 21'h0;     hi = 21'h7F;     end
                    2: begin lo = 21'h80;    hi = 21'h7FF;    end
                    3: begin lo = 21'h800;   hi = 21'hFFFF;   end
                    default: begin lo = 21'h10000; hi = MAX_SCALAR; end
                endcase
                cp = 21'($urandom_range(hi, lo));
                if ($urandom_range(0, 9) == 0) cp = $urandom_range(0, 1) ? hi : lo;
                if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
                case (len)
                    1: seq[0] = {1'b0, cp[6:0]};
                    2: begin
                        seq[0] = {3'b110, cp[10:6]};
                        seq[1] = {2'b10, cp[5:0]};
                    end
                    3: begin
                        seq[0] = {4'b1110, cp[15:12]};
                        seq[1] = {2'b10, cp[11:6]};
                        seq[2] = {2'b10, cp[5:0]};
                    end
                    default: begin
                        seq[0] = {5'b11110, cp[20:18]};
                        seq[1] = {2'b10, cp[17:12]};
                        seq[2] = {2'b10, cp[11:6]};
                        seq[3] = {2'b10, cp[5:0]};
                    end
                endcase
                if (kind == UNIT_RAW) begin
                    // random payload reaches overlong, surrogate and out-of-range forms
                    for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom_range(0, 63))};
                    case (len)
                        2: seq[0] = $urandom_range(0, 1) ? {7'b1100000, 1'($urandom_range(0, 1))}
                                                         : {3'b110, 5'($urandom_range(0, 31))};
                        3: seq[0] = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'hE0 : 8'hED)
                                                         : {4'b1110, 4'($urandom_range(0, 15))};
                        4: seq[0] = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'hF0 : 8'hF4)
                                                         : {5'b11110, 3'($urandom_range(0, 7))};
                        default: ;
                    endcase
                end
                keep = (kind == UNIT_CUT) ? $urandom_range(1, len - 1) : len;
                for (int i = 0; i < keep; i++) push_byte(seq[i], eos && i == keep - 1);
                counted = keep;
            end
        endcase
    endtask

    // Driver: accept, then present the next transaction or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) decode_transaction(s_data);
            if (!s_valid || s_ready) begin
                if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= byte_stream.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_cps.size() == 0) begin
                    $error("unexpected result: code_point %h", m_data.code_point);
                    fail_count++;
                end else begin
                    want = expected_cps.pop_front();
                    if (m_data.code_point !== want.code_point) begin
                        $error("code_point: expected %h, got %h",
                               want.code_point, m_data.code_point);
                        fail_count++;
                    end
                    if (m_data.is_error !== want.is_error) begin
                        $error("is_error: expected %b, got %b", want.is_error, m_data.is_error);
                        fail_count++;
                    end
                    if (m_data.truncated !== want.truncated) begin
                        $error("truncated: expected %b, got %b",
                               want.truncated, m_data.truncated);
                        fail_count++;
                    end
                    if (m_data.byte_count !== want.byte_count) begin
                        $error("byte_count: expected %0d, got %0d",
                               want.byte_count, m_data.byte_count);
                        fail_count++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, m_data.last_of_run);
                        fail_count++;
                    end
                end
            end
            // hold off once for a long stretch so the input backs up
            if (!hold_done && results_seen >= 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int counted;
        int added;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        push_byte(8'h00); push_byte(8'h7F);
        push_byte(8'h80); push_byte(8'hFF);
        push_byte(8'hC2); push_byte(8'h80);
        push_byte(8'hC0); push_byte(8'h80);
        push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);
        push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
        push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hE2); push_byte(8'h82); push_byte(8'h41);
        // bare flush mid-sequence, then a new lead with end of stream
        push_byte(8'hF0); push_byte(8'h90); push_flush(1'b0); push_byte(8'h80);
        push_byte(8'hC2, 1'b1);
        push_byte(8'hE1); push_flush(1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 11; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            counted = 0;
            while (counted < UNITS_ITEMS) begin
                queue_random_unit(added);
                counted += added;
            end
            while (byte_stream.size() != 0 || s_valid || expected_cps.size() != 0)
                @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_cps.size() == 0)
            $display("utf8_stream_decoder_tb passed");
        else
            $display("utf8_stream_decoder_tb failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("utf8_stream_decoder_tb failed");
        $finish;
    end

endmodule

[sim.f]
hdl/u8d_pkg.sv
hdl/u8d_front.sv
hdl/u8d_queue.sv
hdl/u8d_back.sv
hdl/utf8_stream_decoder.sv
hdl/u8d_checker.sv
bench/utf8_stream_decoder_tb.sv
